>>> rtl/core/tdt_pkg.sv
package tdt_pkg;

  // Identifier storage is always the full 12 bytes carried on the port
  localparam int unsigned EPC_BYTES = 12;
  localparam int unsigned EPC_W     = 8 * EPC_BYTES;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned RSSI_W    = 8;
  localparam int unsigned OUT_NUM_W = 8;

  localparam int unsigned DEF_TABLE_DEPTH = 128;
  localparam int unsigned DEF_ID_BYTES    = 12;

  // Probe broadcast to every cell while a sighting is scanned
  typedef struct packed {
    logic [EPC_W-1:0]     epc;
    logic [LEN_W-1:0]     len;
    logic [EPC_BYTES-1:0] mask;
    logic [RSSI_W-1:0]    rssi;
  } key_t;

  // Token walking down the cell chain
  typedef struct packed {
    logic act;
    logic hit;
  } tok_t;

  // Bytes that take part in a compare: the first min(len, id_bytes) bytes
  function automatic logic [EPC_BYTES-1:0] byte_mask(input logic [LEN_W-1:0] len,
                                                     input int unsigned id_bytes);
    int unsigned n;
    logic [EPC_BYTES-1:0] m;
    n = int'(len);
    if (n > id_bytes) begin
      n = id_bytes;
    end
    for (int unsigned k = 0; k < EPC_BYTES; k++) begin
      m[k] = (k < n);
    end
    return m;
  endfunction

endpackage

>>> rtl/core/tdt_stream_if.sv
interface tdt_in_if;
  logic                              valid;
  logic                              ready;
  logic [31:0]                       epc_head;
  logic [63:0]                       epc_tail;
  logic [tdt_pkg::LEN_W-1:0]         epc_length;
  logic signed [tdt_pkg::RSSI_W-1:0] signal_strength;

  modport source (output valid, epc_head, epc_tail, epc_length, signal_strength,
                  input ready);
  modport sink (input valid, epc_head, epc_tail, epc_length, signal_strength,
                output ready);
endinterface

interface tdt_out_if;
  logic                           valid;
  logic                           ready;
  logic                           is_new;
  logic [tdt_pkg::OUT_NUM_W-1:0]  slot;
  logic [tdt_pkg::OUT_NUM_W-1:0]  entry_count;

  modport source (output valid, is_new, slot, entry_count, input ready);
  modport sink (input valid, is_new, slot, entry_count, output ready);
endinterface

>>> rtl/core/tdt_cell.sv
module tdt_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned CNT_W    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CNT_W-1:0]    count,
  input  tdt_pkg::key_t       key,
  input  tdt_pkg::tok_t       tok_in,
  input  logic [CNT_W-1:0]    slot_in,
  input  logic                wr_en,
  input  logic [CNT_W-1:0]    wr_sel,
  output tdt_pkg::tok_t       tok_out,
  output logic [CNT_W-1:0]    slot_out
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  logic [tdt_pkg::EPC_W-1:0]  epc_r;
  logic [tdt_pkg::LEN_W-1:0]  len_r;
  logic [tdt_pkg::RSSI_W-1:0] strength_r;

  tdt_pkg::tok_t    tok_r;
  tdt_pkg::tok_t    tok_nxt;
  logic [CNT_W-1:0] slot_r;
  logic [CNT_W-1:0] slot_nxt;
  logic             bytes_eq;
  logic             match;

  always_comb begin
    bytes_eq = 1'b1;
    for (int unsigned k = 0; k < tdt_pkg::EPC_BYTES; k++) begin
      if (key.mask[k] &&
          (epc_r[8*(tdt_pkg::EPC_BYTES-1-k) +: 8] != key.epc[8*(tdt_pkg::EPC_BYTES-1-k) +: 8]))
      begin
        bytes_eq = 1'b0;
      end
    end
  end

  // Only the first match claims the token; entries at or above the count are skipped
  assign match = tok_in.act && !tok_in.hit && (MY_IDX < count) &&
                 (len_r == key.len) && bytes_eq;

  always_comb begin
    tok_nxt.act = tok_in.act;
    tok_nxt.hit = tok_in.hit | match;
    slot_nxt    = match ? MY_IDX : slot_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (wr_en && (wr_sel == MY_IDX)) begin
      epc_r      <= key.epc;
      len_r      <= key.len;
      strength_r <= key.rssi;
    end else if (match) begin
      strength_r <= key.rssi;
    end
  end

  assign tok_out  = tok_r;
  assign slot_out = slot_r;

endmodule

>>> rtl/core/tag_dedup_table.sv
// tag_dedup_table: lookup-or-insert table of distinct tag identifiers.
// Input channel (in_chan): one transaction is one sighting, the identifier
// bytes (epc_head holds bytes 0..3, epc_tail bytes 4..11, MSB first), the
// number of valid bytes and a signed signal strength.
// Result channel (out_chan): one transaction per sighting, with is_new,
// the slot matched or written (TABLE_DEPTH when the table is full and the
// sighting was not stored) and the entry count after the update.
// On input acceptance a start register injects a token that walks a chain
// of TABLE_DEPTH cells, one cell per cycle; at the chain end the block
// decides and appends into the result registers, then loads the result into
// the output register once it is free. A sighting is taken only once the last
// is through: in_chan.ready rises at the edge that loads that result.
// One sighting is scanned at a time; in_chan.ready is high only when idle.
// Reset clears the entry count and the chain tokens; the cell contents are
// left as they are and are never read before they are written.
// When the receiver stalls, the result holds in the output register; a new
// sighting may be taken and scanned meanwhile, and its result waits in a
// holding state until the output register frees up.
module tag_dedup_table #(
  parameter int unsigned TABLE_DEPTH = tdt_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned ID_BYTES    = tdt_pkg::DEF_ID_BYTES
) (
  input  logic clk,
  input  logic rst_n,
  tdt_in_if.sink    in_chan,
  tdt_out_if.source out_chan
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_V = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  tdt_pkg::key_t key_r;
  logic          start_r;

  // Result waiting for the output register
  logic             res_new_r;
  logic [CNT_W-1:0] res_slot_r;
  logic [CNT_W-1:0] res_count_r;

  logic                            out_valid_r;
  logic                            out_new_r;
  logic [tdt_pkg::OUT_NUM_W-1:0]   out_slot_r;
  logic [tdt_pkg::OUT_NUM_W-1:0]   out_count_r;
  logic [CNT_W+tdt_pkg::OUT_NUM_W-1:0] slot_ext;
  logic [CNT_W+tdt_pkg::OUT_NUM_W-1:0] count_ext;

  tdt_pkg::tok_t    tok   [0:TABLE_DEPTH];
  logic [CNT_W-1:0] slot_c[0:TABLE_DEPTH];

  logic in_fire;
  logic scan_end;
  logic wr_en;
  logic out_free;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign scan_end = (state_r == ST_SCAN) && tok[TABLE_DEPTH].act;
  // Append on a miss while there is still room
  assign wr_en    = scan_end && !tok[TABLE_DEPTH].hit && (count_r < DEPTH_V);
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready = (state_r == ST_IDLE);

  // Inject the token at the head of the chain
  assign tok[0].act = start_r;
  assign tok[0].hit = 1'b0;
  assign slot_c[0]  = DEPTH_V;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tdt_cell #(
      .CELL_IDX(i),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count   (count_r),
      .key     (key_r),
      .tok_in  (tok[i]),
      .slot_in (slot_c[i]),
      .wr_en   (wr_en),
      .wr_sel  (count_r),
      .tok_out (tok[i+1]),
      .slot_out(slot_c[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign count_nxt = wr_en ? count_r + 1'b1 : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      start_r <= in_fire;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture the probe, the decision and the result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r.epc  <= {in_chan.epc_head, in_chan.epc_tail};
      key_r.len  <= in_chan.epc_length;
      key_r.mask <= tdt_pkg::byte_mask(in_chan.epc_length, ID_BYTES);
      key_r.rssi <= in_chan.signal_strength;
    end
    if (scan_end) begin
      res_new_r   <= !tok[TABLE_DEPTH].hit;
      res_count_r <= count_nxt;
      if (tok[TABLE_DEPTH].hit) begin
        res_slot_r <= slot_c[TABLE_DEPTH];
      end else if (count_r < DEPTH_V) begin
        res_slot_r <= count_r;
      end else begin
        res_slot_r <= DEPTH_V;
      end
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_new_r   <= res_new_r;
      out_slot_r  <= slot_ext[tdt_pkg::OUT_NUM_W-1:0];
      out_count_r <= count_ext[tdt_pkg::OUT_NUM_W-1:0];
    end
  end

  assign slot_ext  = {{tdt_pkg::OUT_NUM_W{1'b0}}, res_slot_r};
  assign count_ext = {{tdt_pkg::OUT_NUM_W{1'b0}}, res_count_r};

  assign out_chan.valid       = out_valid_r;
  assign out_chan.is_new      = out_new_r;
  assign out_chan.slot        = out_slot_r;
  assign out_chan.entry_count = out_count_r;

  // The entry count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_V)
    else $error("entry count above table depth");

  // The count moves only upward, one entry at a time
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> (count_r == $past(count_r) + 1'b1))
    else $error("entry count jumped");

  // A token leaves the chain only while a scan is in progress
  a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[TABLE_DEPTH].act |-> (state_r == ST_SCAN))
    else $error("stray token at end of cell chain");

  // A fresh result appears only out of the holding state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside of the holding state");

endmodule

>>> sim/tb.sv
module tb;

  localparam int unsigned EPC_BYTES      = tdt_pkg::EPC_BYTES;
  localparam int unsigned EPC_W          = tdt_pkg::EPC_W;
  localparam int unsigned LEN_W          = tdt_pkg::LEN_W;
  localparam int unsigned RSSI_W         = tdt_pkg::RSSI_W;
  localparam int unsigned OUT_NUM_W      = tdt_pkg::OUT_NUM_W;
  localparam int unsigned TABLE_DEPTH    = tdt_pkg::DEF_TABLE_DEPTH;
  localparam int unsigned ID_BYTES       = tdt_pkg::DEF_ID_BYTES;
  // The longest quiet stretch in a correct run is the receiver hold-off plus one scan.
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // One scan walks the whole cell chain, then decides and loads the result.
  localparam int unsigned DRAIN_CYCLES   = TABLE_DEPTH + 16;

  // One sighting as the sender sees it; byte 0 sits in the top byte of epc.
  typedef struct {
    logic [EPC_W-1:0]         epc;
    logic [LEN_W-1:0]         len;
    logic signed [RSSI_W-1:0] rssi;
  } sighting_t;

  // What the table reports back for one sighting.
  typedef struct {
    logic                 is_new;
    logic [OUT_NUM_W-1:0] slot;
    logic [OUT_NUM_W-1:0] entry_count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  tdt_in_if  in_chan();
  tdt_out_if out_chan();

  tag_dedup_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ID_BYTES   (ID_BYTES)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the tag table. Only entries below known_count are ever
  // read, so the unwritten tail of the arrays never matters.
  logic [EPC_W-1:0]  known_epc  [TABLE_DEPTH];
  logic [LEN_W-1:0]  known_len  [TABLE_DEPTH];
  logic [RSSI_W-1:0] known_rssi [TABLE_DEPTH];
  int unsigned       known_count = 0;

  // Verdicts predicted at input acceptance, oldest first.
  verdict_t    pending_verdicts[$];
  int unsigned mismatches = 0;

  // Traffic shaping knobs, set by the test tasks and read by the driver and
  // the result sink.
  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_requests = 0;

  // Number of leading bytes that take part in a compare.
  function automatic int unsigned compared_bytes(input logic [LEN_W-1:0] len);
    return (int'(len) > ID_BYTES) ? ID_BYTES : int'(len);
  endfunction

  function automatic bit same_tag(input logic [EPC_W-1:0] a, input logic [EPC_W-1:0] b,
                                  input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if (a[EPC_W-1-8*k -: 8] != b[EPC_W-1-8*k -: 8]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Look the sighting up in the shadow table; refresh the strength on a hit,
  // append on a miss while there is room, and return the expected verdict.
  function automatic verdict_t dedup_sighting(input sighting_t s);
    verdict_t v;
    v.is_new = 1'b1;
    v.slot   = OUT_NUM_W'(TABLE_DEPTH);
    for (int unsigned i = 0; i < known_count; i++) begin
      if (known_len[i] == s.len && same_tag(known_epc[i], s.epc, compared_bytes(s.len))) begin
        known_rssi[i] = s.rssi;
        v.is_new      = 1'b0;
        v.slot        = OUT_NUM_W'(i);
        break;
      end
    end
    if (v.is_new && known_count < TABLE_DEPTH) begin
      v.slot                  = OUT_NUM_W'(known_count);
      known_epc[known_count]  = s.epc;
      known_len[known_count]  = s.len;
      known_rssi[known_count] = s.rssi;
      known_count++;
    end
    v.entry_count = OUT_NUM_W'(known_count);
    return v;
  endfunction

  function automatic sighting_t make_sighting(input logic [31:0] head, input logic [63:0] tail,
                                              input logic [LEN_W-1:0] len,
                                              input logic signed [RSSI_W-1:0] rssi);
    sighting_t s;
    s.epc  = {head, tail};
    s.len  = len;
    s.rssi = rssi;
    return s;
  endfunction

  // Mostly repeats of stored tags with fresh junk past the length, some near
  // misses (one compared byte or the length changed) and some fresh tags.
  function automatic sighting_t random_sighting();
    sighting_t        s;
    logic [EPC_W-1:0] noise;
    int unsigned      pick;
    int unsigned      roll;
    int unsigned      n;
    int unsigned      k;
    noise  = {$urandom, $urandom, $urandom};
    s.rssi = RSSI_W'($urandom);
    pick   = $urandom_range(99);
    if (known_count == 0 || pick < 15) begin
      s.epc = noise;
      roll  = $urandom_range(99);
      if (roll < 5) begin
        s.len = '0;
      end else if (roll < 15) begin
        s.len = LEN_W'($urandom_range(15, ID_BYTES + 1));
      end else begin
        s.len = LEN_W'($urandom_range(ID_BYTES, 1));
      end
    end else begin
      k     = $urandom_range(known_count - 1);
      s.epc = known_epc[k];
      s.len = known_len[k];
      n     = compared_bytes(s.len);
      for (k = n; k < EPC_BYTES; k++) begin
        s.epc[EPC_W-1-8*k -: 8] = noise[EPC_W-1-8*k -: 8];
      end
      if (pick < 25) begin
        if (n == 0 || $urandom_range(1) == 1) begin
          s.len = s.len + LEN_W'($urandom_range(15, 1));
        end else begin
          k = $urandom_range(n - 1);
          s.epc[EPC_W-1-8*k -: 8] ^= 8'($urandom_range(255, 1));
        end
      end
    end
    return s;
  endfunction

  // Offer one sighting, idling first at the current rate, and hold it until
  // the block takes it. Called right after a rising edge.
  task automatic send_sighting(input sighting_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.epc_head        <= s.epc[EPC_W-1 -: 32];
    in_chan.epc_tail        <= s.epc[63:0];
    in_chan.epc_length      <= s.len;
    in_chan.signal_strength <= s.rssi;
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
    pending_verdicts.push_back(dedup_sighting(s));
  endtask

  // Walk the matching rules on an empty table: length zero, bytes past the
  // length, lengths above the compared width, and single-bit differences.
  task automatic test_match_rules();
    idle_pct  = 0;
    stall_pct = 0;
    send_sighting(make_sighting(32'h0, 64'h0, 4'd0, -8'sd128));
    send_sighting(make_sighting('1, '1, 4'd0, 8'sd127));        // any length zero matches
    send_sighting(make_sighting('1, '1, 4'd12, 8'sd127));
    send_sighting(make_sighting('1, 64'hFFFF_FFFF_FFFF_FFFE, 4'd12, 8'sd0));
    send_sighting(make_sighting('1, 64'hFFFF_FFFF_FFFF_FF00, 4'd11, 8'sd1));
    send_sighting(make_sighting('1, 64'hFFFF_FFFF_FFFF_FF5A, 4'd11, -8'sd1)); // junk past length
    send_sighting(make_sighting('1, '1, 4'd13, 8'sd2));         // same bytes, longer length
    send_sighting(make_sighting('1, '1, 4'd14, 8'sd3));
    send_sighting(make_sighting('1, '1, 4'd15, 8'sd4));
    send_sighting(make_sighting('1, '1, 4'd15, -8'sd2));
    send_sighting(make_sighting('1, '1, 4'd12, -8'sd3));
    send_sighting(make_sighting(32'h8000_0000, 64'h0123_4567_89AB_CDEF, 4'd1, 8'sd5));
    send_sighting(make_sighting(32'h80FF_FFFF, 64'h0, 4'd1, 8'sd6));
    send_sighting(make_sighting(32'h7F00_0000, 64'h0, 4'd1, 8'sd7));
    send_sighting(make_sighting(32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 4'd12, 8'sd8));
    send_sighting(make_sighting(32'hAAAA_AAAA, 64'h5555_5555_5555_5554, 4'd12, 8'sd9));
    send_sighting(make_sighting(32'h2AAA_AAAA, 64'h5555_5555_5555_5555, 4'd12, 8'sd10));
    send_sighting(make_sighting(32'hDEAD_BEEF, 64'hCAFE_0000_0000_0000, 4'd5, 8'sd11));
    send_sighting(make_sighting(32'hDEAD_BEEF, 64'hCA12_3456_789A_BCDE, 4'd5, -8'sd12));
    send_sighting(make_sighting(32'hDEAD_BEEF, 64'hCBFE_0000_0000_0000, 4'd5, 8'sd13));
  endtask

  // Random sightings at a given idle and stall rate. The table fills up
  // partway through, so later phases exercise the full-table path.
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle,
                                     input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) begin
      send_sighting(random_sighting());
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // so the output register and the holding state fill and the input stalls.
  task automatic test_input_stall();
    idle_pct  = 0;
    stall_pct = 0;
    hold_requests++;
    repeat (8) begin
      send_sighting(random_sighting());
    end
  endtask

  // Result sink: drive ready at random, or hold it low for HOLD_CYCLES once
  // a hold-off has been asked for.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left      = 0;
    hold_seen      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare every accepted result against the oldest predicted verdict.
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with nothing pending: is_new=%0d slot=%0d entry_count=%0d",
               out_chan.is_new, out_chan.slot, out_chan.entry_count);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_chan.is_new !== want.is_new) begin
          $error("is_new: expected %0d, got %0d", want.is_new, out_chan.is_new);
          mismatches++;
        end
        if (out_chan.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_chan.slot);
          mismatches++;
        end
        if (out_chan.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_chan.entry_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tag_dedup_table test failed");
    $finish;
  end

  initial begin : run_tests
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.epc_head        = '0;
    in_chan.epc_tail        = '0;
    in_chan.epc_length      = '0;
    in_chan.signal_strength = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_match_rules();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 77, 0);
    test_random_traffic(250, 0, 77);
    test_input_stall();
    test_random_traffic(250, 30, 30);

    // Drop valid, drain what is pending, then give a stray result time to show.
    in_chan.valid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tag_dedup_table test passed");
    end else begin
      $display("tag_dedup_table test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tdt_pkg.sv
rtl/core/tdt_stream_if.sv
rtl/core/tdt_cell.sv
rtl/core/tag_dedup_table.sv
sim/tb.sv
